/* rtl/isort_pkg.sv */
// shared types and constants for the insertion sorter
package isort_pkg;

   localparam int MAX_ITEMS = 32;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int DATA_W    = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_of_run;
      logic                     overflow;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic insert;
      logic shift_down;
      logic valid;
      logic slot;
   } cell_ctl_type;

endpackage

/* rtl/isort_cell.sv */
// one compare-and-shift cell of the sorting chain
module isort_cell (
   input  logic                                clock,
   input  isort_pkg::cell_ctl_type             ctl,
   input  logic signed [isort_pkg::DATA_W-1:0] new_value,
   input  logic signed [isort_pkg::DATA_W-1:0] left_value,
   input  logic                                left_gt,
   input  logic signed [isort_pkg::DATA_W-1:0] right_value,
   output logic signed [isort_pkg::DATA_W-1:0] value,
   output logic                                gt
);
   import isort_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // strictly greater, so equal values keep arrival order
   assign gt    = ctl.valid && (value_ff > new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.shift_down) begin
         value_in = right_value;
      end else if (ctl.insert && (gt || ctl.slot)) begin
         value_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/insertion_sorter_top.sv */
// top level of the streaming insertion sorter
//
// Values enter one per cycle while the block is loading; a row of MAX_ITEMS
// compare-and-shift cells inserts each value into place in the cycle it is
// accepted, after any equal values. The transaction marked last closes the
// set: from the next cycle the block presents the n held values in ascending
// order, one per cycle while rsp_ready is high, by shifting the cell row
// towards cell 0, and takes no input until the final result (last_of_run)
// has been accepted. Values beyond MAX_ITEMS are dropped and every result
// of that set carries overflow.
module insertion_sorter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  isort_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output isort_pkg::rsp_type rsp_data
);
   import isort_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff,  drop_in;

   logic req_fire, rsp_fire, full;

   logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
   logic                     cell_gt    [MAX_ITEMS];
   cell_ctl_type             cell_ctl   [MAX_ITEMS];

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));

   assign rsp_data.sorted_value = cell_value[0];
   assign rsp_data.last_of_run  = (count_ff == CNT_W'(1));
   assign rsp_data.overflow     = drop_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic                     left_gt;
      logic signed [DATA_W-1:0] right_value;

      assign cell_ctl[i].insert     = req_fire && !full;
      assign cell_ctl[i].shift_down = rsp_fire;
      assign cell_ctl[i].valid      = (CNT_W'(i) < count_ff);
      // first empty cell takes the value when nothing above it moves up
      assign cell_ctl[i].slot       = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_end
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .new_value   (req_data.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

endmodule
